### sv/vga_extended_register_port_top_macros.svh
// ----------------------------------------------------------------------------
// vga_extended_register_port_top_macros
// Assertion helpers for the extended register port.
// ----------------------------------------------------------------------------
`ifndef VGA_EXTENDED_REGISTER_PORT_TOP_MACROS_SVH
`define VGA_EXTENDED_REGISTER_PORT_TOP_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define VXRP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vxrp: implication check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define VXRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vxrp: next-cycle check failed");

`endif

### sv/vxrp_pkg.sv
// ----------------------------------------------------------------------------
// vxrp_pkg
// Constants and helpers for the extended display adapter register port.
// ----------------------------------------------------------------------------
package vxrp_pkg;

  localparam int CrtcEntriesDef = 32;
  localparam int ExtEntriesDef  = 32;

  // configuration port
  localparam int PaddrW = 4;
  localparam int PdataW = 32;

  typedef enum logic [1:0] {
    CFG_COLOR_ADDRESSING = 2'd0,
    CFG_OVERSCAN_COLOR   = 2'd1,
    CFG_DIAG_PLANE_PAIR  = 2'd2
  } cfg_reg_e;

  // i/o ports
  localparam logic [15:0] PortEnable    = 16'h03C3;
  localparam logic [15:0] PortCrtcIndex = 16'h03D4;
  localparam logic [15:0] PortCrtcData  = 16'h03D5;
  localparam logic [15:0] PortStatus    = 16'h03DA;
  localparam logic [15:0] PortExtIndex  = 16'h03DE;
  localparam logic [15:0] PortExtData   = 16'h03DF;
  localparam logic [15:0] PortHiMask    = 16'hFFF0;
  localparam logic [15:0] PortColorBase = 16'h03D0;
  localparam logic [15:0] PortMonoBase  = 16'h03B0;
  localparam logic [15:0] MonoAliasXor  = 16'h0060;

  // fixed file entries
  localparam int CrtcProtEntry      = 17;
  localparam int CrtcPartialEntry   = 7;
  localparam int CrtcNoRetimeLo     = 14;
  localparam int CrtcNoRetimeHi     = 16;
  localparam int ExtIdEntry         = 16;
  localparam int ExtWindowEntry     = 13;
  localparam int ExtBankEntry       = 17;
  localparam int ExtTimingEntry     = 20;

  localparam logic [7:0] ExtIdValue      = 8'h18;
  localparam logic [7:0] ExtEntry0Reset  = 8'h08;
  localparam logic [7:0] DisabledReadVal = 8'hFF;
  localparam logic [7:0] CrtcPartialMask = 8'h10;
  localparam logic [7:0] StatusDiagMask  = 8'h30;
  localparam logic [7:0] RowDoubleMask   = 8'h0C;

  // reset contents of the extended file
  function automatic logic [7:0] ext_reset_value(input int k);
    ext_reset_value = (k == 0) ? ExtEntry0Reset : 8'h00;
  endfunction

  // status bits 5:4 from two planes of the overscan colour
  function automatic logic [1:0] diag_bits(input logic [7:0] color, input logic [1:0] sel);
    logic lo;
    logic hi;
    case (sel)
      2'd0:    begin lo = color[0]; hi = color[2]; end
      2'd1:    begin lo = color[4]; hi = color[5]; end
      2'd2:    begin lo = color[1]; hi = color[3]; end
      2'd3:    begin lo = color[6]; hi = color[7]; end
      default: begin lo = 1'b0;     hi = 1'b0;     end
    endcase
    diag_bits = {hi, lo};
  endfunction

endpackage

### sv/vga_extended_register_port_top.sv
// ----------------------------------------------------------------------------
// vga_extended_register_port_top
// CRTC and extended register files behind byte-wide i/o port requests.
// ----------------------------------------------------------------------------
// channel  direction  handshake               payload
// in       slave      in_valid_i / in_stall_o  action, port_addr, write_data,
//                                              timing_status
// out      master     out_valid_o / out_stall_i read_data, passthrough, banks,
//                                              window and timing flags
// cfg      apb slave  psel/penable/pready      color_addressing, overscan_color,
//                                              diag_plane_pair
//
// one request per cycle sustained while out_stall_i is low; held in the input register, then the result register
// the register files update when a request leaves the input register
// reset sets the register files, indices and valid flags at once, no clearing pass
// a stalled result holds in the result register while the input register still
// takes one more request; in_stall_o rises only when both are full
module vga_extended_register_port_top #(
  parameter int CRTC_ENTRIES = vxrp_pkg::CrtcEntriesDef,
  parameter int EXT_ENTRIES  = vxrp_pkg::ExtEntriesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        action_i,
  input  logic [15:0]                 port_addr_i,
  input  logic [7:0]                  write_data_i,
  input  logic [7:0]                  timing_status_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  read_data_o,
  output logic                        passthrough_o,
  output logic [3:0]                  rd_bank_o,
  output logic [3:0]                  wr_bank_o,
  output logic                        window_off_o,
  output logic                        retime_pulse_o,
  output logic                        flipflop_clear_o,
  output logic                        start_high_bit_o,
  output logic                        row_offset_double_o,
  output logic                        interlace_on_o,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vxrp_pkg::PaddrW-1:0] paddr,
  input  logic [vxrp_pkg::PdataW-1:0] pwdata,
  output logic [vxrp_pkg::PdataW-1:0] prdata,
  output logic                        pready
);

  localparam int CIDX_W = $clog2(CRTC_ENTRIES);
  localparam int EIDX_W = $clog2(EXT_ENTRIES);

  // configuration registers
  logic       color_addressing_q;
  logic [7:0] overscan_color_q;
  logic [1:0] diag_plane_pair_q;
  logic       cfg_wr;
  logic [1:0] cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_addressing_q <= 1'b1;
      overscan_color_q   <= '0;
      diag_plane_pair_q  <= '0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        vxrp_pkg::CFG_COLOR_ADDRESSING: color_addressing_q <= pwdata[0];
        vxrp_pkg::CFG_OVERSCAN_COLOR:   overscan_color_q   <= pwdata[7:0];
        vxrp_pkg::CFG_DIAG_PLANE_PAIR:  diag_plane_pair_q  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      vxrp_pkg::CFG_COLOR_ADDRESSING: prdata = {31'd0, color_addressing_q};
      vxrp_pkg::CFG_OVERSCAN_COLOR:   prdata = {24'd0, overscan_color_q};
      vxrp_pkg::CFG_DIAG_PLANE_PAIR:  prdata = {30'd0, diag_plane_pair_q};
      default:                        prdata = '0;
    endcase
  end

  // input register and handshake
  logic        in_valid_q;
  logic        action_q;
  logic [15:0] port_addr_q;
  logic [7:0]  write_data_q;
  logic [7:0]  timing_status_q;
  logic        out_valid_q;
  logic        advance;
  logic        fire;
  logic        in_take;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      action_q        <= action_i;
      port_addr_q     <= port_addr_i;
      write_data_q    <= write_data_i;
      timing_status_q <= timing_status_i;
    end
  end

  // architectural state
  logic             port_enable_q;
  logic [7:0]       crtc_index_q;
  logic [7:0]       ext_index_q;
  logic [7:0]       crtc_file_q [CRTC_ENTRIES];
  logic [7:0]       ext_file_q  [EXT_ENTRIES];
  logic [CIDX_W-1:0] crtc_e;
  logic [EIDX_W-1:0] ext_e;

  assign crtc_e = crtc_index_q[CIDX_W-1:0];
  assign ext_e  = ext_index_q[EIDX_W-1:0];

  // decode and per-request work
  logic        active;
  logic        aliased;
  logic [15:0] addr;
  logic        prot;
  logic [7:0]  crtc_cur;
  logic [7:0]  crtc_val;
  logic        enable_wr;
  logic        cidx_wr;
  logic        eidx_wr;
  logic        crtc_wr;
  logic        ext_wr;
  logic [7:0]  rd_d;
  logic        pass_d;
  logic        retime_d;
  logic        ffclr_d;

  assign active  = port_enable_q || (port_addr_q == vxrp_pkg::PortEnable);
  assign aliased = ((port_addr_q & vxrp_pkg::PortHiMask) == vxrp_pkg::PortColorBase
                    || (port_addr_q & vxrp_pkg::PortHiMask) == vxrp_pkg::PortMonoBase)
                   && (port_addr_q < vxrp_pkg::PortExtIndex) && !color_addressing_q;
  assign addr    = aliased ? (port_addr_q ^ vxrp_pkg::MonoAliasXor) : port_addr_q;
  assign prot    = crtc_file_q[CIDX_W'(vxrp_pkg::CrtcProtEntry)][7];
  assign crtc_cur = crtc_file_q[crtc_e];

  always_comb begin
    rd_d      = '0;
    pass_d    = 1'b0;
    retime_d  = 1'b0;
    ffclr_d   = 1'b0;
    enable_wr = 1'b0;
    cidx_wr   = 1'b0;
    eidx_wr   = 1'b0;
    crtc_wr   = 1'b0;
    ext_wr    = 1'b0;
    crtc_val  = write_data_q;
    if (!active) begin
      rd_d = action_q ? 8'h00 : vxrp_pkg::DisabledReadVal;
    end else begin
      case (addr)
        vxrp_pkg::PortEnable: begin
          if (action_q) enable_wr = 1'b1;
          else rd_d = {7'd0, port_enable_q};
        end
        vxrp_pkg::PortCrtcIndex: begin
          if (action_q) cidx_wr = 1'b1;
          else rd_d = crtc_index_q;
        end
        vxrp_pkg::PortCrtcData: begin
          if (!action_q) begin
            rd_d = crtc_cur;
          end else if (!(prot && crtc_e < CIDX_W'(vxrp_pkg::CrtcPartialEntry))) begin
            // protected entry 7 keeps all but its line-compare bit
            if (prot && crtc_e == CIDX_W'(vxrp_pkg::CrtcPartialEntry)) begin
              crtc_val = (crtc_cur & ~vxrp_pkg::CrtcPartialMask)
                         | (write_data_q & vxrp_pkg::CrtcPartialMask);
            end
            retime_d = (crtc_cur != crtc_val)
                       && (crtc_e < CIDX_W'(vxrp_pkg::CrtcNoRetimeLo)
                           || crtc_e > CIDX_W'(vxrp_pkg::CrtcNoRetimeHi));
            crtc_wr  = 1'b1;
            pass_d   = 1'b1;
          end
        end
        vxrp_pkg::PortStatus: begin
          if (action_q) begin
            pass_d = 1'b1;
          end else begin
            ffclr_d = 1'b1;
            rd_d    = (timing_status_q & ~vxrp_pkg::StatusDiagMask)
                      | {2'b00, vxrp_pkg::diag_bits(overscan_color_q, diag_plane_pair_q),
                         4'h0};
          end
        end
        vxrp_pkg::PortExtIndex: begin
          if (action_q) eidx_wr = 1'b1;
          else rd_d = ext_index_q;
        end
        vxrp_pkg::PortExtData: begin
          if (action_q) ext_wr = 1'b1;
          else if (ext_e == EIDX_W'(vxrp_pkg::ExtIdEntry)) rd_d = vxrp_pkg::ExtIdValue;
          else rd_d = ext_file_q[ext_e];
        end
        default: pass_d = 1'b1;
      endcase
    end
  end

  // extended entries as they stand after this request
  logic [7:0] ext_window_nx;
  logic [7:0] ext_bank_nx;
  logic [7:0] ext_timing_nx;

  assign ext_window_nx = (ext_wr && ext_e == EIDX_W'(vxrp_pkg::ExtWindowEntry))
                         ? write_data_q : ext_file_q[EIDX_W'(vxrp_pkg::ExtWindowEntry)];
  assign ext_bank_nx   = (ext_wr && ext_e == EIDX_W'(vxrp_pkg::ExtBankEntry))
                         ? write_data_q : ext_file_q[EIDX_W'(vxrp_pkg::ExtBankEntry)];
  assign ext_timing_nx = (ext_wr && ext_e == EIDX_W'(vxrp_pkg::ExtTimingEntry))
                         ? write_data_q : ext_file_q[EIDX_W'(vxrp_pkg::ExtTimingEntry)];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_enable_q <= 1'b0;
      crtc_index_q  <= '0;
      ext_index_q   <= '0;
      for (int k = 0; k < CRTC_ENTRIES; k++) crtc_file_q[k] <= '0;
      for (int k = 0; k < EXT_ENTRIES; k++) ext_file_q[k] <= vxrp_pkg::ext_reset_value(k);
    end else if (fire) begin
      if (enable_wr) port_enable_q <= write_data_q[0];
      if (cidx_wr) crtc_index_q <= write_data_q;
      if (eidx_wr) ext_index_q <= write_data_q;
      if (crtc_wr) crtc_file_q[crtc_e] <= crtc_val;
      if (ext_wr) ext_file_q[ext_e] <= write_data_q;
    end
  end

  // result register
  logic [7:0] read_data_q;
  logic       passthrough_q;
  logic [3:0] rd_bank_q;
  logic [3:0] wr_bank_q;
  logic       window_off_q;
  logic       retime_pulse_q;
  logic       flipflop_clear_q;
  logic       start_high_bit_q;
  logic       row_offset_double_q;
  logic       interlace_on_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      read_data_q         <= rd_d;
      passthrough_q       <= pass_d;
      rd_bank_q           <= ext_bank_nx[3:0];
      wr_bank_q           <= ext_bank_nx[7:4];
      window_off_q        <= ext_window_nx[7];
      retime_pulse_q      <= retime_d;
      flipflop_clear_q    <= ffclr_d;
      start_high_bit_q    <= ext_timing_nx[3];
      row_offset_double_q <= |(ext_window_nx & vxrp_pkg::RowDoubleMask);
      interlace_on_q      <= ext_timing_nx[7];
    end
  end

  assign out_valid_o         = out_valid_q;
  assign read_data_o         = read_data_q;
  assign passthrough_o       = passthrough_q;
  assign rd_bank_o           = rd_bank_q;
  assign wr_bank_o           = wr_bank_q;
  assign window_off_o        = window_off_q;
  assign retime_pulse_o      = retime_pulse_q;
  assign flipflop_clear_o    = flipflop_clear_q;
  assign start_high_bit_o    = start_high_bit_q;
  assign row_offset_double_o = row_offset_double_q;
  assign interlace_on_o      = interlace_on_q;

  `include "vga_extended_register_port_top_macros.svh"

  // a status read is never handed on to the generic core
  `VXRP_ASSERT_IMP(a_ffclr_not_pass, out_valid_q && flipflop_clear_q, !passthrough_q)
  // retiming only comes from a stored crtc write, which always passes through
  `VXRP_ASSERT_IMP(a_retime_pass, out_valid_q && retime_pulse_q, passthrough_q)
  // the input side stalls only behind a held result
  `VXRP_ASSERT_IMP(a_stall_cause, in_stall_o, in_valid_q && out_valid_q && out_stall_i)
  // a disabled block leaves its enable and indices alone
  `VXRP_ASSERT_NEXT(a_disabled_hold, fire && !port_enable_q && port_addr_q != vxrp_pkg::PortEnable, $stable(port_enable_q) && $stable(crtc_index_q) && $stable(ext_index_q))

endmodule
